>>> rtl/adxbd_pkg.sv
// ----------------------------------------------------------------------------
// ADX block decoder package
// Shared widths, register indexes, reset values and the control bundle types.
// ----------------------------------------------------------------------------
package adxbd_pkg;

   localparam int CHANNEL_SLOTS_DEFAULT = 2;

   localparam int BYTE_W   = 8;
   localparam int SAMPLE_W = 16;
   localparam int POS_W    = 6;
   localparam int C1_W     = 14;
   localparam int C2_W     = 13;
   localparam int BB_W     = 6;
   localparam int CC_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   // Product and sum widths of the prediction path.
   localparam int P1_W   = 31;   // 15-bit signed coefficient times 16-bit sample
   localparam int P2_W   = 29;   // 13-bit signed coefficient times 16-bit sample
   localparam int PSUM_W = 32;
   localparam int Q12    = 12;
   localparam int PRED_W = PSUM_W - Q12;
   localparam int NS_W   = 21;   // signed nibble times unsigned scale
   localparam int SUM_W  = 22;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 22'sd32767;
   localparam logic signed [SUM_W-1:0] SUM_MIN = -22'sd32768;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_ONE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_TWO     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd3;

   localparam logic [C1_W-1:0] COEFF_ONE_RESET     = 14'd7400;
   localparam logic [C2_W-1:0] COEFF_TWO_RESET     = 13'd4850;  // -3342 as 13 bits
   localparam logic [BB_W-1:0] BLOCK_BYTES_RESET   = 6'd18;
   localparam logic [CC_W-1:0] CHANNEL_COUNT_RESET = 2'd2;
   localparam logic [BB_W-1:0] BLOCK_BYTES_MIN     = 6'd3;
   localparam logic [POS_W-1:0] FIRST_NIBBLE_POS   = 6'd2;

   typedef struct packed {
      logic take_byte;     // a request byte is accepted this cycle
      logic load_p1;       // register coeff_one times history_one
      logic load_p2;       // register coeff_two times history_two and nibble times scale
      logic write_sample;  // finish the sample, update history, load the result register
      logic low_nibble;    // 1 while working on the low nibble
   } ctrl_cmd_type;

   typedef struct packed {
      logic nibble_byte;   // the next byte carries nibbles rather than scale
      logic out_free;      // the result register can take a new sample
   } dpath_status_type;

endpackage

>>> rtl/adxbd_ctrl.sv
// ----------------------------------------------------------------------------
// ADX block decoder controller
// Sequences the three datapath steps for each nibble of a nibble byte.
// ----------------------------------------------------------------------------
module adxbd_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  adxbd_pkg::dpath_status_type  status,
   output adxbd_pkg::ctrl_cmd_type      cmd
);
   import adxbd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL1 = 2'd1;
   localparam logic [1:0] ST_MUL2 = 2'd2;
   localparam logic [1:0] ST_SUM  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       low_ff, low_in;
   logic       take;

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in         = state_ff;
      low_in           = low_ff;
      cmd.take_byte    = 1'b0;
      cmd.load_p1      = 1'b0;
      cmd.load_p2      = 1'b0;
      cmd.write_sample = 1'b0;
      cmd.low_nibble   = low_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.take_byte = take;
            if (take && status.nibble_byte) begin
               state_in = ST_MUL1;
               low_in   = 1'b0;
            end
         end
         ST_MUL1: begin
            cmd.load_p1 = 1'b1;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.load_p2 = 1'b1;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            // The sample waits here until the result register is free.
            if (status.out_free) begin
               cmd.write_sample = 1'b1;
               if (low_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MUL1;
                  low_in   = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         low_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         low_ff   <= low_in;
      end
   end

endmodule

>>> rtl/adxbd_dpath.sv
// ----------------------------------------------------------------------------
// ADX block decoder datapath
// Configuration registers, block position, scale, channel history, the
// prediction multipliers and the result register.
// ----------------------------------------------------------------------------
module adxbd_dpath #(
   parameter int CHANNEL_SLOTS = adxbd_pkg::CHANNEL_SLOTS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [adxbd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [adxbd_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic [adxbd_pkg::BYTE_W-1:0]           req_data_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [adxbd_pkg::SAMPLE_W-1:0]  rsp_sample,
   output logic                                   rsp_channel,
   output logic                                   rsp_last_of_pair,
   input  adxbd_pkg::ctrl_cmd_type                cmd,
   output adxbd_pkg::dpath_status_type            status
);
   import adxbd_pkg::*;

   localparam int SLOT_W = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;

   logic [C1_W-1:0]  coeff_one_ff;
   logic [C2_W-1:0]  coeff_two_ff;
   logic [BB_W-1:0]  block_bytes_ff;
   logic [CC_W-1:0]  channel_count_ff;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             cur_ch_ff, cur_ch_in;
   logic [15:0]      scale_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic             ch_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic signed [SAMPLE_W-1:0] hist_one_ff [CHANNEL_SLOTS];
   logic signed [SAMPLE_W-1:0] hist_two_ff [CHANNEL_SLOTS];

   logic signed [P1_W-1:0] p1_ff, p1_in;
   logic signed [P2_W-1:0] p2_ff, p2_in;
   logic signed [NS_W-1:0] ns_ff, ns_in;

   logic signed [SAMPLE_W-1:0] rsp_sample_ff, sample_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_channel_ff, rsp_last_ff;

   logic [BB_W-1:0]  bb;
   logic             stereo;
   logic             ch_now;
   logic [SLOT_W-1:0] slot_now;
   logic [POS_W:0]   pos_next;
   logic signed [3:0] nibble;
   logic signed [SAMPLE_W-1:0] h1, h2;
   logic signed [PSUM_W-1:0] psum;
   logic signed [PRED_W-1:0] pred;
   logic signed [SUM_W-1:0]  sum;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_one_ff     <= COEFF_ONE_RESET;
         coeff_two_ff     <= COEFF_TWO_RESET;
         block_bytes_ff   <= BLOCK_BYTES_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COEFF_ONE:     coeff_one_ff     <= csr_data[C1_W-1:0];
            CSR_COEFF_TWO:     coeff_two_ff     <= csr_data[C2_W-1:0];
            CSR_BLOCK_BYTES:   block_bytes_ff   <= csr_data[BB_W-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[CC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Block position and channel alternation.
   always_comb begin
      bb       = (block_bytes_ff < BLOCK_BYTES_MIN) ? BLOCK_BYTES_MIN : block_bytes_ff;
      stereo   = (channel_count_ff >= CC_W'(2));
      ch_now   = stereo ? cur_ch_ff : 1'b0;
      slot_now = (CHANNEL_SLOTS > 1) ? SLOT_W'(ch_now) : '0;
      pos_next = {1'b0, pos_ff} + (POS_W+1)'(1);
      pos_in    = pos_ff;
      cur_ch_in = cur_ch_ff;
      if (cmd.take_byte) begin
         if (pos_next >= {1'b0, bb}) begin
            pos_in    = '0;
            cur_ch_in = stereo ? ~cur_ch_ff : 1'b0;
         end else begin
            pos_in = pos_next[POS_W-1:0];
         end
      end
   end

   assign status.nibble_byte = (pos_ff >= FIRST_NIBBLE_POS);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         cur_ch_ff <= 1'b0;
         scale_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         cur_ch_ff <= cur_ch_in;
         if (cmd.take_byte && pos_ff == '0) begin
            scale_ff[15:8] <= req_data_byte;
         end
         if (cmd.take_byte && pos_ff == POS_W'(1)) begin
            scale_ff[7:0] <= req_data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         byte_ff <= req_data_byte;
         ch_ff   <= ch_now;
         slot_ff <= slot_now;
      end
   end

   // Prediction and sample arithmetic.
   always_comb begin
      nibble = cmd.low_nibble ? $signed(byte_ff[3:0]) : $signed(byte_ff[7:4]);
      h1     = hist_one_ff[slot_ff];
      h2     = hist_two_ff[slot_ff];
      p1_in  = $signed({1'b0, coeff_one_ff}) * h1;
      p2_in  = $signed(coeff_two_ff) * h2;
      ns_in  = nibble * $signed({1'b0, scale_ff});
      psum   = {{(PSUM_W-P1_W){p1_ff[P1_W-1]}}, p1_ff}
             + {{(PSUM_W-P2_W){p2_ff[P2_W-1]}}, p2_ff};
      // An arithmetic shift rounds the Q12 sum toward minus infinity.
      pred   = psum[PSUM_W-1:Q12];
      sum    = {{(SUM_W-PRED_W){pred[PRED_W-1]}}, pred}
             + {{(SUM_W-NS_W){ns_ff[NS_W-1]}}, ns_ff};
      if (sum > SUM_MAX) begin
         sample_in = SUM_MAX[SAMPLE_W-1:0];
      end else if (sum < SUM_MIN) begin
         sample_in = SUM_MIN[SAMPLE_W-1:0];
      end else begin
         sample_in = sum[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_p1) begin
         p1_ff <= p1_in;
      end
      if (cmd.load_p2) begin
         p2_ff <= p2_in;
         ns_ff <= ns_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNEL_SLOTS; i++) begin
            hist_one_ff[i] <= '0;
            hist_two_ff[i] <= '0;
         end
      end else if (cmd.write_sample) begin
         hist_two_ff[slot_ff] <= hist_one_ff[slot_ff];
         hist_one_ff[slot_ff] <= sample_in;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.write_sample) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_sample) begin
         rsp_sample_ff  <= sample_in;
         rsp_channel_ff <= ch_ff;
         rsp_last_ff    <= cmd.low_nibble;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = rsp_sample_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_last_of_pair = rsp_last_ff;

endmodule

>>> rtl/adx_adpcm_block_decoder_core.sv
// ----------------------------------------------------------------------------
// ADX ADPCM block decoder core
// Decodes a stream of ADX block bytes into clamped 16-bit samples.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                                  Handshake
//  req_     in         data_byte[7:0]                           req_valid / req_ready
//  rsp_     out        sample[15:0], channel, last_of_pair      rsp_valid / rsp_ready
//  csr_     in         index[1:0], data[13:0]                   csr_valid / csr_ready
//
// A scale byte is accepted and stored. A nibble byte is accepted, then each
// nibble passes the steps of the single chained prediction filter in order:
// coefficient one product, coefficient two and scale products, sum and clamp.
// A finished sample waits in the result register while the block goes on; the
// filter stalls in its sum step only while that register is still full.
// Reset is synchronous and restores the register defaults and clears history.
// The configuration port is always ready.
module adx_adpcm_block_decoder_core #(
   parameter int CHANNEL_SLOTS = adxbd_pkg::CHANNEL_SLOTS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [adxbd_pkg::BYTE_W-1:0]           req_data_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [adxbd_pkg::SAMPLE_W-1:0]  rsp_sample,
   output logic                                   rsp_channel,
   output logic                                   rsp_last_of_pair,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [adxbd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [adxbd_pkg::CSR_DATA_W-1:0]       csr_data
);
   import adxbd_pkg::*;

   ctrl_cmd_type     cmd;
   dpath_status_type status;

   assign csr_ready = 1'b1;

   adxbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   adxbd_dpath #(
      .CHANNEL_SLOTS (CHANNEL_SLOTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .rsp_channel      (rsp_channel),
      .rsp_last_of_pair (rsp_last_of_pair),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

>>> rtl/adxbd_checker.sv
// ----------------------------------------------------------------------------
// ADX block decoder port checker
// Watches the core's ports for result hold and ordering, reset behavior and csr readiness.
// ----------------------------------------------------------------------------
module adxbd_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [adxbd_pkg::SAMPLE_W-1:0]  rsp_sample,
   input logic                                   rsp_channel,
   input logic                                   rsp_last_of_pair,
   input logic                                   csr_valid,
   input logic                                   csr_ready
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample)
         && $stable(rsp_channel) && $stable(rsp_last_of_pair))
      else $error("result changed while stalled");

   // While a high-nibble sample is pending, the low nibble is still in work.
   a_pair_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_pair |-> !req_ready)
      else $error("request taken between the samples of one byte");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result pending after reset");

   // The configuration port never stalls.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind adx_adpcm_block_decoder_core adxbd_checker u_adxbd_checker (.*);
